/* rtl/core/i2cm_pkg.sv */
`timescale 1ns / 1ps

package i2cm_pkg;

    // Item classes as they arrive on the input side.
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_DATA  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START     = 4'd1,
        PH_ADDR      = 4'd2,
        PH_ADDR_ACK  = 4'd3,
        PH_WAIT_DATA = 4'd4,
        PH_WR_BIT    = 4'd5,
        PH_WR_ACK    = 4'd6,
        PH_RD_BIT    = 4'd7,
        PH_RD_ACK    = 4'd8,
        PH_STOP_OK   = 4'd9,
        PH_STOP_NACK = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BUS_BUSY  = 2'd1,
        ST_ADDR_NACK = 2'd2
    } t_status;

    // Bit 1 is SCL, bit 0 is SDA; a one releases the line.
    localparam logic [1:0] LINES_RELEASED = 2'b11;
    localparam logic [3:0] BYTE_BITS      = 4'd8;

    typedef struct packed {
        t_kind       kind;
        logic        sda_in;
        logic [7:0]  address_byte;
        logic        read_mode;
        logic [7:0]  byte_count;
        logic [7:0]  write_byte;
    } t_cmd;

    typedef struct packed {
        logic        scl_out;
        logic        sda_out;
        logic        busy_res;
        logic        need_data;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic        done_res;
        t_status     status;
    } t_result;

endpackage

/* rtl/core/i2cm_queue.sv */
`timescale 1ns / 1ps

module i2cm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/core/i2cm_front.sv */
`timescale 1ns / 1ps

module i2cm_front #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  logic [1:0]     i_kind,
    input  logic           i_sda_in,
    input  logic [7:0]     i_address_byte,
    input  logic           i_read_mode,
    input  logic [7:0]     i_byte_count,
    input  logic [7:0]     i_write_byte,
    output i2cm_pkg::t_cmd o_cmd,
    output logic           o_cmd_empty,
    input  logic           i_cmd_pop
);
    import i2cm_pkg::*;

    t_cmd            cmd;
    logic [$bits(t_cmd)-1:0] q_out;

    // Classify the item and keep only the fields its class uses.
    always_comb begin
        cmd = '0;
        case (t_kind'(i_kind))
            KIND_TICK: begin
                cmd.kind   = KIND_TICK;
                cmd.sda_in = i_sda_in;
            end
            KIND_START: begin
                cmd.kind         = KIND_START;
                cmd.address_byte = i_address_byte;
                cmd.read_mode    = i_read_mode;
                cmd.byte_count   = i_byte_count;
            end
            KIND_DATA: begin
                cmd.kind       = KIND_DATA;
                cmd.write_byte = i_write_byte;
            end
            default: begin
                cmd.kind = KIND_NONE;
            end
        endcase
    end

    i2cm_queue #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd),
        .o_full  (full),
        .i_pop   (i_cmd_pop),
        .o_data  (q_out),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = t_cmd'(q_out);

endmodule

/* rtl/core/i2cm_engine.sv */
`timescale 1ns / 1ps

module i2cm_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  i2cm_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output i2cm_pkg::t_result o_res,
    output logic              o_res_push,
    input  logic              i_res_full
);
    import i2cm_pkg::*;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_quarter, n_quarter;
    logic [3:0]  r_bit_cnt, n_bit_cnt;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic        r_dir_read, n_dir_read;
    logic        r_data_ready, n_data_ready;
    logic [1:0]  r_lines, n_lines;

    logic        take;
    logic [7:0]  rd_byte;
    logic        rd_valid;
    logic        done;
    t_status     status;
    logic [3:0]  bit_inc;
    logic [7:0]  bytes_dec;

    // Phase that follows a finished byte and its acknowledge.
    function automatic t_phase after_byte(input logic [7:0] left, input logic dir_read);
        t_phase ph;
        if (left == 8'd0) begin
            ph = PH_STOP_OK;
        end else if (dir_read) begin
            ph = PH_RD_BIT;
        end else begin
            ph = PH_WAIT_DATA;
        end
        return ph;
    endfunction

    assign take       = !i_cmd_empty && !i_res_full;
    assign o_cmd_pop  = take;
    assign o_res_push = take;
    assign bit_inc    = r_bit_cnt + 1'b1;
    assign bytes_dec  = r_bytes_left - 1'b1;

    always_comb begin
        n_phase      = r_phase;
        n_quarter    = r_quarter;
        n_bit_cnt    = r_bit_cnt;
        n_shift      = r_shift;
        n_bytes_left = r_bytes_left;
        n_dir_read   = r_dir_read;
        n_data_ready = r_data_ready;
        n_lines      = r_lines;
        rd_byte      = 8'd0;
        rd_valid     = 1'b0;
        done         = 1'b0;
        status       = ST_OK;

        case (i_cmd.kind)
            KIND_START: begin
                if (r_phase == PH_IDLE) begin
                    n_shift      = i_cmd.address_byte;
                    n_dir_read   = i_cmd.read_mode;
                    n_bytes_left = i_cmd.byte_count;
                    n_data_ready = 1'b0;
                    n_bit_cnt    = 4'd0;
                    n_quarter    = 2'd0;
                    n_lines      = LINES_RELEASED;
                    n_phase      = PH_START;
                end
            end
            KIND_DATA: begin
                if (r_phase == PH_WAIT_DATA && !r_data_ready) begin
                    n_shift      = i_cmd.write_byte;
                    n_data_ready = 1'b1;
                end
            end
            KIND_TICK: begin
                case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_START: begin
                        if (r_quarter == 2'd0) begin
                            if (!i_cmd.sda_in) begin
                                n_lines      = LINES_RELEASED;
                                n_phase      = PH_IDLE;
                                n_quarter    = 2'd0;
                                n_bit_cnt    = 4'd0;
                                n_data_ready = 1'b0;
                                done         = 1'b1;
                                status       = ST_BUS_BUSY;
                            end else begin
                                n_lines[0] = 1'b0;
                                n_quarter  = 2'd1;
                            end
                        end else if (r_quarter == 2'd1) begin
                            if (i_cmd.sda_in) begin
                                n_lines      = LINES_RELEASED;
                                n_phase      = PH_IDLE;
                                n_quarter    = 2'd0;
                                n_bit_cnt    = 4'd0;
                                n_data_ready = 1'b0;
                                done         = 1'b1;
                                status       = ST_BUS_BUSY;
                            end else begin
                                n_quarter = 2'd2;
                            end
                        end else begin
                            n_phase   = PH_ADDR;
                            n_quarter = 2'd0;
                            n_bit_cnt = 4'd0;
                        end
                    end
                    PH_WAIT_DATA: begin
                        if (r_data_ready) begin
                            n_data_ready = 1'b0;
                            n_phase      = PH_WR_BIT;
                            n_quarter    = 2'd0;
                            n_bit_cnt    = 4'd0;
                        end
                    end
                    PH_ADDR, PH_ADDR_ACK, PH_WR_BIT, PH_WR_ACK, PH_RD_BIT, PH_RD_ACK: begin
                        n_quarter = r_quarter + 1'b1;
                        case (r_quarter)
                            2'd0: n_lines[1] = 1'b0;
                            2'd2: n_lines[1] = 1'b1;
                            2'd1: begin
                                if (r_phase == PH_ADDR || r_phase == PH_WR_BIT) begin
                                    n_lines[0] = r_shift[7];
                                    n_shift    = {r_shift[6:0], 1'b0};
                                end else if (r_phase == PH_RD_ACK) begin
                                    // The final read byte gets a NACK.
                                    n_lines[0] = (r_bytes_left == 8'd1);
                                end else begin
                                    n_lines[0] = 1'b1;
                                end
                            end
                            default: begin
                                case (r_phase)
                                    PH_ADDR, PH_WR_BIT: begin
                                        n_bit_cnt = bit_inc;
                                        if (bit_inc >= BYTE_BITS) begin
                                            n_bit_cnt = 4'd0;
                                            n_phase   = (r_phase == PH_ADDR) ?
                                                        PH_ADDR_ACK : PH_WR_ACK;
                                        end
                                    end
                                    PH_RD_BIT: begin
                                        n_shift   = {r_shift[6:0], i_cmd.sda_in};
                                        n_bit_cnt = bit_inc;
                                        if (bit_inc >= BYTE_BITS) begin
                                            n_bit_cnt = 4'd0;
                                            rd_byte   = {r_shift[6:0], i_cmd.sda_in};
                                            rd_valid  = 1'b1;
                                            n_phase   = PH_RD_ACK;
                                        end
                                    end
                                    PH_ADDR_ACK: begin
                                        if (i_cmd.sda_in) begin
                                            n_phase = PH_STOP_NACK;
                                        end else begin
                                            n_bit_cnt = 4'd0;
                                            n_phase   = after_byte(r_bytes_left, r_dir_read);
                                        end
                                    end
                                    default: begin
                                        n_bytes_left = bytes_dec;
                                        n_bit_cnt    = 4'd0;
                                        n_phase      = after_byte(bytes_dec, r_dir_read);
                                    end
                                endcase
                            end
                        endcase
                    end
                    PH_STOP_OK, PH_STOP_NACK: begin
                        n_quarter = r_quarter + 1'b1;
                        case (r_quarter)
                            2'd0: n_lines[1] = 1'b0;
                            2'd1: n_lines[0] = 1'b0;
                            2'd2: n_lines[1] = 1'b1;
                            default: begin
                                n_lines[0]   = 1'b1;
                                n_phase      = PH_IDLE;
                                n_quarter    = 2'd0;
                                n_bit_cnt    = 4'd0;
                                n_data_ready = 1'b0;
                                done         = 1'b1;
                                status       = (r_phase == PH_STOP_NACK) ?
                                               ST_ADDR_NACK : ST_OK;
                            end
                        endcase
                    end
                    default: begin
                        n_lines   = LINES_RELEASED;
                        n_phase   = PH_IDLE;
                        n_quarter = 2'd0;
                    end
                endcase
            end
            default: begin
            end
        endcase

        o_res.scl_out    = n_lines[1];
        o_res.sda_out    = n_lines[0];
        o_res.busy_res   = (n_phase != PH_IDLE);
        o_res.need_data  = (n_phase == PH_WAIT_DATA) && !n_data_ready;
        o_res.read_byte  = rd_byte;
        o_res.read_valid = rd_valid;
        o_res.done_res   = done;
        o_res.status     = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_quarter    <= 2'd0;
            r_bit_cnt    <= 4'd0;
            r_shift      <= 8'd0;
            r_bytes_left <= 8'd0;
            r_dir_read   <= 1'b0;
            r_data_ready <= 1'b0;
            r_lines      <= LINES_RELEASED;
        end else if (take) begin
            r_phase      <= n_phase;
            r_quarter    <= n_quarter;
            r_bit_cnt    <= n_bit_cnt;
            r_shift      <= n_shift;
            r_bytes_left <= n_bytes_left;
            r_dir_read   <= n_dir_read;
            r_data_ready <= n_data_ready;
            r_lines      <= n_lines;
        end
    end

endmodule

/* rtl/core/i2c_master_byte_transfer_core.sv */
`timescale 1ns / 1ps

// I2C master byte-transfer core, stepped by items rather than by a free clock.
// Every input item is one of: a quarter-bit tick carrying the sampled SDA level,
// a start command (address byte, direction, byte count), a write byte, or a
// no-op. Each item accepted on push/full yields exactly one result item on
// empty/pop, in order, carrying the SCL and SDA drive, busy, need_data, a
// received byte with its valid flag, and done with its status.
// The front stage classifies items into a command queue; the engine pops one
// command per cycle while the result queue has room, updates the bus state
// machine and pushes the result into the result queue. A result passes
// through the command queue and then the result queue before it appears on
// the result ports. The core sustains one item per cycle while the receiver
// keeps popping: the only loop is the state update of the engine.
// When the receiver stops popping, the result queue fills, the engine holds,
// then the command queue fills and full rises; nothing is dropped.
// Synchronous reset empties both queues, returns the engine to idle and
// releases both bus lines.

module i2c_master_byte_transfer_core #(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_kind,
    input  logic       i_sda_in,
    input  logic [7:0] i_address_byte,
    input  logic       i_read_mode,
    input  logic [7:0] i_byte_count,
    input  logic [7:0] i_write_byte,
    output logic       empty,
    input  logic       pop,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic       o_need_data,
    output logic [7:0] o_read_byte,
    output logic       o_read_valid,
    output logic       o_done_res,
    output logic [1:0] o_status
);
    import i2cm_pkg::*;

    t_cmd    cmd;
    logic    cmd_empty;
    logic    cmd_pop;
    t_result eng_res;
    logic    res_push;
    logic    res_full;
    logic [$bits(t_result)-1:0] res_bits;
    t_result res;

    // Front: classification and command queue.
    i2cm_front #(
        .DEPTH (CMD_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_sda_in       (i_sda_in),
        .i_address_byte (i_address_byte),
        .i_read_mode    (i_read_mode),
        .i_byte_count   (i_byte_count),
        .i_write_byte   (i_write_byte),
        .o_cmd          (cmd),
        .o_cmd_empty    (cmd_empty),
        .i_cmd_pop      (cmd_pop)
    );

    // Back: the bus state machine, one command per cycle while results fit.
    i2cm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (eng_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    // Result queue decouples the engine from a stalling receiver.
    i2cm_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (eng_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_bits),
        .o_empty (empty)
    );

    assign res          = t_result'(res_bits);
    assign o_scl_out    = res.scl_out;
    assign o_sda_out    = res.sda_out;
    assign o_busy_res   = res.busy_res;
    assign o_need_data  = res.need_data;
    assign o_read_byte  = res.read_byte;
    assign o_read_valid = res.read_valid;
    assign o_done_res   = res.done_res;
    assign o_status     = res.status;

endmodule
